FILE: rtl/core/bgba_pkg.sv
// Shared constants for the block group allocator: defaults, field widths,
// status, opcode and register codes. No dependencies.
package bgba_pkg;

  localparam int GROUP_BITS_DEF = 8192;
  localparam int WORD_BITS_DEF  = 32;

  localparam int POS_W  = 13;
  localparam int CNT_W  = 14;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_META     = 2'd2;
  localparam logic [STAT_W-1:0] ST_OUTSIDE  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] REG_GROUP_BLOCKS    = 3'd0;
  localparam logic [2:0] REG_BLOCK_MAP_POS   = 3'd1;
  localparam logic [2:0] REG_INODE_MAP_POS   = 3'd2;
  localparam logic [2:0] REG_INODE_TABLE_POS = 3'd3;
  localparam logic [2:0] REG_INODE_TABLE_LEN = 3'd4;

endpackage

FILE: rtl/core/bgba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bgba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bitmap_group_block_allocator_top.sv
// Block group allocator top level: sequencer, word buffer and APB registers.
// Depends on bgba_pkg and bgba_ram.
//
// One request at a time. The bitmap lives in a RAM of WORD_BITS-wide words
// (WORD_BITS must be a power of two); one word at a time is held in a
// buffer register and walked one bit per clock, pausing on a word change.
// A word change first writes the buffered word back when it is dirty, then
// reads the new word through the S_WAIT state. After reset the RAM is cleared
// one word per cycle, during which req_ready stays low; register writes are
// taken throughout. The result sits in an output register, so req_ready
// returns as soon as that register is free.
module bitmap_group_block_allocator_top
  import bgba_pkg::*;
#(
  parameter int GROUP_BITS = GROUP_BITS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // APB-style register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              opcode,
  input  logic [POS_W-1:0]  position,
  input  logic              has_goal,
  input  logic [CNT_W-1:0]  request_count,
  input  logic              use_window,
  input  logic [POS_W-1:0]  window_first,
  input  logic [POS_W-1:0]  window_last,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  first_bit,
  output logic [CNT_W-1:0]  done_count,
  output logic [CNT_W-1:0]  already_free
);

  localparam int MAP_WORDS = (GROUP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int OW        = $clog2(WORD_BITS);
  localparam int LG        = $clog2(GROUP_BITS + 1);
  localparam int IW        = (LG + 1 > 15) ? LG + 1 : 15;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WAIT   = 4'd2;
  localparam logic [3:0] S_AINIT  = 4'd3;
  localparam logic [3:0] S_ASCAN  = 4'd4;
  localparam logic [3:0] S_ABACK  = 4'd5;
  localparam logic [3:0] S_ACLAIM = 4'd6;
  localparam logic [3:0] S_AEND   = 4'd7;
  localparam logic [3:0] S_AUNDO  = 4'd8;
  localparam logic [3:0] S_FINIT  = 4'd9;
  localparam logic [3:0] S_FLOOP  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // configuration registers
  logic [CNT_W-1:0] group_blocks, inode_table_len;
  logic [POS_W-1:0] block_map_pos, inode_map_pos, inode_table_pos;

  // latched request
  logic             goal_q, win_q;
  logic [IW-1:0]    pos_q, want_q, wf_q, wl_q;

  // sequencer
  logic [3:0]       state, ret_state;
  logic [AW-1:0]    clr_cnt;
  logic [IW-1:0]    bit_i, first, claimed, cnt, freed, already;
  logic [IW-1:0]    start_b, end_b;
  logic [2:0]       back;
  logic             gok;

  // word buffer
  logic [WORD_BITS-1:0] wbuf, rdata;
  logic [AW-1:0]        buf_idx, pend_idx;
  logic                 buf_ok, dirty;

  // result
  logic [STAT_W-1:0] res_status;
  logic [IW-1:0]     res_first, res_done, res_already;

  // RAM port
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [IW-1:0] n_size, acc_bit, c_start, c_end, c_bit;
  logic [AW-1:0] acc_idx;
  logic [OW-1:0] acc_off;
  logic          need_acc, hit, cur, c_gok;

  function automatic logic in_rng(input logic [IW-1:0] v, input logic [IW-1:0] f,
                                  input logic [IW-1:0] len);
    logic [IW-1:0] d;
    d = v - f;
    return (v >= f) && (d < len);
  endfunction

  function automatic logic meta_clash(input logic [IW-1:0] f, input logic [IW-1:0] c,
                                      input logic [IW-1:0] bmp, input logic [IW-1:0] imp,
                                      input logic [IW-1:0] itp, input logic [IW-1:0] itl);
    logic [IW-1:0] last;
    last = f + c - IW'(1);
    return in_rng(bmp, f, c) || in_rng(imp, f, c) ||
           in_rng(f, itp, itl) || in_rng(last, itp, itl);
  endfunction

  assign n_size = (IW'(group_blocks) < IW'(GROUP_BITS)) ? IW'(group_blocks)
                                                        : IW'(GROUP_BITS);

  // search bounds for an allocate
  always_comb begin
    c_start = '0;
    c_end   = n_size;
    if (win_q) begin
      if (wf_q != '0) c_start = wf_q;
      if (n_size != '0 && wl_q < n_size - IW'(1)) c_end = wl_q + IW'(1);
    end
    c_gok = goal_q && !(win_q && (pos_q < c_start || pos_q >= c_end));
    c_bit = c_gok ? pos_q : c_start;
  end

  // bit access through the word buffer
  always_comb begin
    acc_bit = (state == S_ABACK) ? bit_i - IW'(1) : bit_i;
    unique case (state)
      S_ASCAN:  need_acc = bit_i < end_b;
      S_ABACK:  need_acc = (bit_i > start_b) && (back != 3'd7);
      S_ACLAIM: need_acc = (claimed < want_q) && (bit_i < end_b);
      S_AUNDO:  need_acc = cnt < claimed;
      S_FLOOP:  need_acc = cnt < want_q;
      default:  need_acc = 1'b0;
    endcase
  end
  assign acc_idx = acc_bit[AW+OW-1:OW];
  assign acc_off = acc_bit[OW-1:0];
  assign hit     = buf_ok && (buf_idx == acc_idx);
  assign cur     = wbuf[acc_off];

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = buf_idx;
    mem_wdata = wbuf;
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (need_acc && !hit) begin
      if (buf_ok && dirty) mem_we = 1'b1;
      else                 mem_re = 1'b1;
    end
  end

  bgba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (acc_idx),
    .rdata (rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign pready    = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      group_blocks    <= CNT_W'(8192);
      block_map_pos   <= POS_W'(0);
      inode_map_pos   <= POS_W'(1);
      inode_table_pos <= POS_W'(2);
      inode_table_len <= CNT_W'(214);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_GROUP_BLOCKS:    group_blocks    <= pwdata[CNT_W-1:0];
        REG_BLOCK_MAP_POS:   block_map_pos   <= pwdata[POS_W-1:0];
        REG_INODE_MAP_POS:   inode_map_pos   <= pwdata[POS_W-1:0];
        REG_INODE_TABLE_POS: inode_table_pos <= pwdata[POS_W-1:0];
        REG_INODE_TABLE_LEN: inode_table_len <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GROUP_BLOCKS:    prdata = 32'(group_blocks);
      REG_BLOCK_MAP_POS:   prdata = 32'(block_map_pos);
      REG_INODE_MAP_POS:   prdata = 32'(inode_map_pos);
      REG_INODE_TABLE_POS: prdata = 32'(inode_table_pos);
      REG_INODE_TABLE_LEN: prdata = 32'(inode_table_len);
      default:             prdata = '0;
    endcase
  end

  // sequencer and word buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      buf_ok    <= 1'b0;
      dirty     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;

      if (need_acc && !hit) begin
        // miss: write back a dirty word first, then fetch
        if (buf_ok && dirty) begin
          dirty <= 1'b0;
        end else begin
          pend_idx  <= acc_idx;
          ret_state <= state;
          state     <= S_WAIT;
        end
      end else begin
        unique case (state)
          S_CLR: begin
            clr_cnt <= clr_cnt + AW'(1);
            if (clr_cnt == AW'(MAP_WORDS - 1)) state <= S_IDLE;
          end
          S_IDLE: begin
            if (req_valid) begin
              goal_q <= has_goal;
              win_q  <= use_window;
              pos_q  <= IW'(position);
              want_q <= IW'(request_count);
              wf_q   <= IW'(window_first);
              wl_q   <= IW'(window_last);
              state  <= (opcode == OP_FREE) ? S_FINIT : S_AINIT;
            end
          end
          S_WAIT: begin
            wbuf    <= rdata;
            buf_idx <= pend_idx;
            buf_ok  <= 1'b1;
            dirty   <= 1'b0;
            state   <= ret_state;
          end
          S_AINIT: begin
            res_status  <= ST_NO_SPACE;
            res_first   <= '0;
            res_done    <= '0;
            res_already <= '0;
            start_b     <= c_start;
            end_b       <= c_end;
            gok         <= c_gok;
            bit_i       <= c_bit;
            claimed     <= '0;
            back        <= '0;
            if (c_bit >= c_end || want_q == '0) state <= S_FIN;
            else                                state <= S_ASCAN;
          end
          S_ASCAN: begin
            if (bit_i >= end_b) begin
              state <= S_FIN;
            end else if (cur) begin
              bit_i <= bit_i + IW'(1);
            end else if (!win_q && !gok) begin
              state <= S_ABACK;
            end else begin
              first <= bit_i;
              state <= S_ACLAIM;
            end
          end
          S_ABACK: begin
            if (need_acc && !cur) begin
              bit_i <= bit_i - IW'(1);
              back  <= back + 3'd1;
            end else begin
              first <= bit_i;
              state <= S_ACLAIM;
            end
          end
          S_ACLAIM: begin
            if (!need_acc) begin
              state <= S_AEND;
            end else if (cur) begin
              if (claimed != '0) begin
                state <= S_AEND;
              end else begin
                bit_i <= bit_i + IW'(1);
                first <= bit_i + IW'(1);
              end
            end else begin
              wbuf[acc_off] <= 1'b1;
              dirty         <= 1'b1;
              claimed       <= claimed + IW'(1);
              bit_i         <= bit_i + IW'(1);
            end
          end
          S_AEND: begin
            if (claimed == '0) begin
              state <= S_FIN;
            end else if (meta_clash(first, claimed, IW'(block_map_pos), IW'(inode_map_pos),
                                    IW'(inode_table_pos), IW'(inode_table_len))) begin
              // roll the run back
              bit_i <= first;
              cnt   <= '0;
              state <= S_AUNDO;
            end else begin
              res_status <= ST_OK;
              res_first  <= first;
              res_done   <= claimed;
              state      <= S_FIN;
            end
          end
          S_AUNDO: begin
            if (!need_acc) begin
              res_status <= ST_META;
              state      <= S_FIN;
            end else begin
              wbuf[acc_off] <= 1'b0;
              dirty         <= 1'b1;
              cnt           <= cnt + IW'(1);
              bit_i         <= bit_i + IW'(1);
            end
          end
          S_FINIT: begin
            res_first   <= '0;
            res_done    <= '0;
            res_already <= '0;
            bit_i       <= pos_q;
            cnt         <= '0;
            freed       <= '0;
            already     <= '0;
            if (want_q == '0 || pos_q >= n_size || want_q > n_size - pos_q) begin
              res_status <= ST_OUTSIDE;
              state      <= S_FIN;
            end else if (meta_clash(pos_q, want_q, IW'(block_map_pos), IW'(inode_map_pos),
                                    IW'(inode_table_pos), IW'(inode_table_len))) begin
              res_status <= ST_META;
              state      <= S_FIN;
            end else begin
              state <= S_FLOOP;
            end
          end
          S_FLOOP: begin
            if (!need_acc) begin
              res_status  <= ST_OK;
              res_done    <= freed;
              res_already <= already;
              state       <= S_FIN;
            end else begin
              if (cur) begin
                wbuf[acc_off] <= 1'b0;
                dirty         <= 1'b1;
                freed         <= freed + IW'(1);
              end else begin
                already <= already + IW'(1);
              end
              cnt   <= cnt + IW'(1);
              bit_i <= bit_i + IW'(1);
            end
          end
          S_FIN: begin
            // hand the result to the output register once it is free
            if (!rsp_valid) begin
              rsp_valid    <= 1'b1;
              status       <= res_status;
              first_bit    <= res_first[POS_W-1:0];
              done_count   <= res_done[CNT_W-1:0];
              already_free <= res_already[CNT_W-1:0];
              state        <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_rw_excl: assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("RAM read and write issued together");
  a_dirty_ok: assert property (@(posedge clk) disable iff (rst) dirty |-> buf_ok)
    else $error("dirty word buffer without a valid word");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
      (state == S_FIN && !rsp_valid) |=> rsp_valid)
    else $error("finished result not presented");
  a_wait_ret: assert property (@(posedge clk) disable iff (rst)
      (state == S_WAIT) |=> buf_ok)
    else $error("fetched word not loaded into buffer");

endmodule
